[rtl/dssm_pkg.sv]
`default_nettype none

package dssm_pkg;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OP_W        = 3;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef logic [OP_W-1:0]        op_t;
    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [STATUS_W-1:0]    status_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [COUNT_OUT_W-1:0] count_out_t;

    localparam op_t OP_PUSH_FIRST  = 3'd0;
    localparam op_t OP_PUSH_SECOND = 3'd1;
    localparam op_t OP_POP_FIRST   = 3'd2;
    localparam op_t OP_POP_SECOND  = 3'd3;
    localparam op_t OP_PEEK        = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    // An empty stack shows all ones as its top word.
    localparam word_t EMPTY_TOP = '1;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_top;
        logic capture;
    } dssm_cmd_t;

    typedef struct packed {
        logic need_read;
    } dssm_stat_t;

endpackage

`default_nettype wire

[rtl/dssm_if.sv]
`default_nettype none

interface dssm_req_if
    import dssm_pkg::*;
();
    logic  valid;
    logic  ready;
    op_t   op;
    word_t value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface dssm_rsp_if
    import dssm_pkg::*;
();
    logic       valid;
    logic       ready;
    status_t    status;
    word_t      popped;
    count_out_t count_first;
    count_out_t count_second;
    word_t      top_first;
    word_t      top_second;

    modport source (output valid, output status, output popped, output count_first,
                    output count_second, output top_first, output top_second,
                    input ready);
    modport sink   (input valid, input status, input popped, input count_first,
                    input count_second, input top_first, input top_second,
                    output ready);
endinterface

`default_nettype wire

[rtl/dual_stack_shared_memory.sv]
// Channel | Dir | Fields
// req     | in  | op, value
// rsp     | out | status, popped, count_first, count_second, top_first, top_second
//
// A transaction passes through the idle, execute and done states, and also a load
// state when a pop must fetch the new top word, since the store has one registered
// read port. A new request is taken only after the done state captures a result.
// The next request is taken while a finished result still waits on rsp.
// Reset clears both stack counts and sets both tops to all ones; the store
// itself is not cleared. A stalled rsp holds the next result in its last stage.
`default_nettype none

module dual_stack_shared_memory
    import dssm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    dssm_req_if.sink   req,
    dssm_rsp_if.source rsp
);

    dssm_cmd_t  cmd;
    dssm_stat_t stat;

    dssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dssm_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_op            (req.op),
        .in_value         (req.value),
        .res_status       (rsp.status),
        .res_popped       (rsp.popped),
        .res_count_first  (rsp.count_first),
        .res_count_second (rsp.count_second),
        .res_top_first    (rsp.top_first),
        .res_top_second   (rsp.top_second)
    );

endmodule

`default_nettype wire

[rtl/dssm_datapath.sv]
`default_nettype none

module dssm_datapath
    import dssm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dssm_cmd_t  cmd,
    output      dssm_stat_t stat,
    input  wire op_t        in_op,
    input  wire word_t      in_value,
    output      status_t    res_status,
    output      word_t      res_popped,
    output      count_out_t res_count_first,
    output      count_out_t res_count_second,
    output      word_t      res_top_first,
    output      word_t      res_top_second
);

    word_t   mem [DEPTH];

    op_t     op_reg;
    word_t   value_reg;
    cnt_t    first_cnt_reg, first_cnt_next;
    cnt_t    second_cnt_reg, second_cnt_next;
    word_t   top_first_reg, top_first_next;
    word_t   top_second_reg, top_second_next;
    status_t status_reg, status_next;
    word_t   popped_reg, popped_next;
    word_t   rdata_reg;

    status_t    res_status_reg;
    word_t      res_popped_reg;
    count_out_t res_count_first_reg;
    count_out_t res_count_second_reg;
    word_t      res_top_first_reg;
    word_t      res_top_second_reg;

    logic [CNT_W:0] fill_sum;
    logic [CNT_W:0] second_top_wide;
    logic           full;
    logic           we;
    addr_t          waddr;
    addr_t          raddr;
    logic           need_read;

    assign fill_sum        = {1'b0, first_cnt_reg} + {1'b0, second_cnt_reg};
    assign full            = (fill_sum >= (CNT_W + 1)'(DEPTH));
    // After a pop from the second stack its new top sits at DEPTH - (count - 1).
    assign second_top_wide = (CNT_W + 1)'(DEPTH + 1) - {1'b0, second_cnt_reg};

    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        top_first_next  = top_first_reg;
        top_second_next = top_second_reg;
        status_next     = ST_OK;
        popped_next     = '0;
        we              = 1'b0;
        waddr           = first_cnt_reg[ADDR_W-1:0];
        raddr           = second_top_wide[ADDR_W-1:0];
        need_read       = 1'b0;
        case (op_reg)
            OP_PUSH_FIRST:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    we             = 1'b1;
                    waddr          = first_cnt_reg[ADDR_W-1:0];
                    first_cnt_next = first_cnt_reg + 1'b1;
                    top_first_next = value_reg;
                end
            end
            OP_PUSH_SECOND:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    we              = 1'b1;
                    waddr           = ADDR_W'(DEPTH - 1) - second_cnt_reg[ADDR_W-1:0];
                    second_cnt_next = second_cnt_reg + 1'b1;
                    top_second_next = value_reg;
                end
            end
            OP_POP_FIRST:
            begin
                if (first_cnt_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    popped_next    = top_first_reg;
                    first_cnt_next = first_cnt_reg - 1'b1;
                    if (first_cnt_reg == cnt_t'(1))
                    begin
                        top_first_next = EMPTY_TOP;
                    end
                    else
                    begin
                        need_read = 1'b1;
                        raddr     = ADDR_W'(first_cnt_reg - cnt_t'(2));
                    end
                end
            end
            OP_POP_SECOND:
            begin
                if (second_cnt_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    popped_next     = top_second_reg;
                    second_cnt_next = second_cnt_reg - 1'b1;
                    if (second_cnt_reg == cnt_t'(1))
                    begin
                        top_second_next = EMPTY_TOP;
                    end
                    else
                    begin
                        need_read = 1'b1;
                        raddr     = second_top_wide[ADDR_W-1:0];
                    end
                end
            end
            default:
            begin
                // Peek and the unused codes leave the stacks alone.
            end
        endcase
    end

    assign stat.need_read = need_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            top_first_reg  <= EMPTY_TOP;
            top_second_reg <= EMPTY_TOP;
        end
        else if (cmd.exec)
        begin
            first_cnt_reg   <= first_cnt_next;
            second_cnt_reg  <= second_cnt_next;
            top_first_reg   <= top_first_next;
            top_second_reg  <= top_second_next;
        end
        else if (cmd.load_top)
        begin
            if (op_reg == OP_POP_FIRST)
            begin
                top_first_reg <= rdata_reg;
            end
            else
            begin
                top_second_reg <= rdata_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
        if (cmd.capture)
        begin
            res_status_reg       <= status_reg;
            res_popped_reg       <= popped_reg;
            res_count_first_reg  <= COUNT_OUT_W'(first_cnt_reg);
            res_count_second_reg <= COUNT_OUT_W'(second_cnt_reg);
            res_top_first_reg    <= top_first_reg;
            res_top_second_reg   <= top_second_reg;
        end
    end

    // Shared word store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
        begin
            mem[waddr] <= value_reg;
        end
        if (cmd.exec && need_read)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign res_status       = res_status_reg;
    assign res_popped       = res_popped_reg;
    assign res_count_first  = res_count_first_reg;
    assign res_count_second = res_count_second_reg;
    assign res_top_first    = res_top_first_reg;
    assign res_top_second   = res_top_second_reg;

endmodule

`default_nettype wire

[rtl/dssm_ctrl.sv]
`default_nettype none

module dssm_ctrl
    import dssm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    output      logic       out_valid,
    input  wire logic       out_ready,
    input  wire dssm_stat_t stat,
    output      dssm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.need_read ? S_LOAD : S_DONE;
            end
            S_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/dssm_checker.sv]
`default_nettype none

module dssm_checker
    import dssm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire status_t    status,
    input wire word_t      popped,
    input wire count_out_t count_first,
    input wire count_out_t count_second,
    input wire word_t      top_first,
    input wire word_t      top_second
);

    logic [COUNT_OUT_W:0] total;

    assign total = {1'b0, count_first} + {1'b0, count_second};

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(popped)
            && $stable(count_first) && $stable(count_second))
        else $error("result changed while stalled");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_OVERFLOW |-> total == (COUNT_OUT_W + 1)'(DEPTH))
        else $error("overflow reported with room left");

    a_first_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && count_first == '0 |-> top_first == EMPTY_TOP)
        else $error("empty first stack shows a top word");

    a_second_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && count_second == '0 |-> top_second == EMPTY_TOP)
        else $error("empty second stack shows a top word");

    a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_UNDERFLOW || status == ST_OVERFLOW) |-> popped == '0)
        else $error("refused transaction returned a word");

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .popped       (rsp.popped),
    .count_first  (rsp.count_first),
    .count_second (rsp.count_second),
    .top_first    (rsp.top_first),
    .top_second   (rsp.top_second)
);

`default_nettype wire
